### rtl/dvc_pkg.sv
// shared constants and helpers for the dotted version compare unit
package dvc_pkg;

	localparam int DIGIT_W = 4;
	localparam logic [DIGIT_W-1:0] DOT_CODE = 4'd10;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam logic [7:0] ASCII_NINE = 8'h39;

	localparam logic [1:0] VERDICT_EQUAL = 2'b00;
	localparam logic [1:0] VERDICT_FIRST = 2'b01;
	localparam logic [1:0] VERDICT_SECOND = 2'b11;

	typedef logic [DIGIT_W-1:0] digit_t;

	// digits become their value, anything else becomes a dot
	function automatic digit_t encode_char(input logic [7:0] code);
		logic [7:0] diff;
		diff = code - ASCII_ZERO;
		if (code >= ASCII_ZERO && code <= ASCII_NINE) begin
			encode_char = diff[DIGIT_W-1:0];
		end else begin
			encode_char = DOT_CODE;
		end
	endfunction

endpackage

### rtl/dvc_char_buf.sv
// character buffer for one version string, registered read
module dvc_char_buf
	import dvc_pkg::*;
#(
	parameter int DEPTH = 256,
	parameter int AW = 8
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  digit_t        wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output digit_t        rd_data
);

	digit_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/dvc_rev_acc.sv
// shared decimal accumulate step: acc * 10 + digit, saturating
module dvc_rev_acc
	import dvc_pkg::*;
#(
	parameter int RB = 32
) (
	input  logic [RB-1:0] acc,
	input  digit_t        digit,
	output logic [RB-1:0] acc_next,
	output logic          sat
);

	logic [RB+3:0] wide;

	always_comb begin
		wide = ({4'b0000, acc} << 3) + ({4'b0000, acc} << 1) + {{RB{1'b0}}, digit};
		sat = |wide[RB+3:RB];
		acc_next = sat ? {RB{1'b1}} : wide[RB-1:0];
	end

endmodule

### rtl/dotted_version_compare_unit.sv
// dotted version compare unit: top level with load logic and compare sequencer
// loading: one character word per cycle, s_tready low from the end word to the result
// compare: address and data steps per stored character, check and compare steps per revision
//   pair and an address step at a string end, set by one read port and the shared accumulator
// result valid and ready again as S_DONE sees output free, via S_CHK after the last equal pair
// reset clears lengths, lost flag, sequencer and output valid; buffers are not cleared
module dotted_version_compare_unit
	import dvc_pkg::*;
#(
	parameter int MAX_CHARS = 256,
	parameter int REVISION_BITS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // char_code[7:0]
	input  logic [1:0] s_tuser,  // string_sel[0], char_valid[1]
	input  logic       s_tlast,  // end_of_load
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // verdict[1:0], zero fill [7:2]
	output logic       m_tuser   // overflow
);

	localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
	localparam int LW = $clog2(MAX_CHARS + 2);
	localparam logic [LW-1:0] MAX_LEN = LW'(MAX_CHARS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK  = 3'd1;
	localparam logic [2:0] S_ADDR = 3'd2;
	localparam logic [2:0] S_DATA = 3'd3;
	localparam logic [2:0] S_CMP  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q;
	logic side_q;
	logic [LW-1:0] len1_q, len2_q, i_q, j_q;
	logic lost_q, sat_q;
	logic [REVISION_BITS-1:0] acc_q, a_q;
	logic [1:0] verdict_q;
	logic out_valid_q;
	logic [1:0] out_verdict_q;
	logic out_ovf_q;

	logic in_acc, store, store1, store2;
	digit_t enc;
	logic [LW-1:0] p_cur, len_cur;
	logic p_in_range;
	logic rd_en1, rd_en2;
	digit_t rd1, rd2, d_cur;
	logic [REVISION_BITS-1:0] acc_next;
	logic acc_sat;
	logic out_free;

	assign s_tready = (state_q == S_IDLE);
	assign in_acc = s_tvalid && s_tready;
	assign store = in_acc && s_tuser[1];
	assign store1 = store && !s_tuser[0] && (len1_q < MAX_LEN);
	assign store2 = store && s_tuser[0] && (len2_q < MAX_LEN);
	assign enc = encode_char(s_tdata);

	assign p_cur = side_q ? j_q : i_q;
	assign len_cur = side_q ? len2_q : len1_q;
	assign p_in_range = (p_cur < len_cur);
	assign rd_en1 = (state_q == S_ADDR) && !side_q && p_in_range;
	assign rd_en2 = (state_q == S_ADDR) && side_q && p_in_range;
	assign d_cur = side_q ? rd2 : rd1;
	assign out_free = !out_valid_q || m_tready;

	dvc_char_buf #(.DEPTH(MAX_CHARS), .AW(AW)) u_buf1 (
		.clk     (clk),
		.wr_en   (store1),
		.wr_addr (len1_q[AW-1:0]),
		.wr_data (enc),
		.rd_en   (rd_en1),
		.rd_addr (i_q[AW-1:0]),
		.rd_data (rd1)
	);

	dvc_char_buf #(.DEPTH(MAX_CHARS), .AW(AW)) u_buf2 (
		.clk     (clk),
		.wr_en   (store2),
		.wr_addr (len2_q[AW-1:0]),
		.wr_data (enc),
		.rd_en   (rd_en2),
		.rd_addr (j_q[AW-1:0]),
		.rd_data (rd2)
	);

	dvc_rev_acc #(.RB(REVISION_BITS)) u_acc (
		.acc      (acc_q),
		.digit    (d_cur),
		.acc_next (acc_next),
		.sat      (acc_sat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			side_q <= 1'b0;
			len1_q <= '0;
			len2_q <= '0;
			i_q <= '0;
			j_q <= '0;
			lost_q <= 1'b0;
			sat_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (store1) begin
						len1_q <= len1_q + 1'b1;
					end
					if (store2) begin
						len2_q <= len2_q + 1'b1;
					end
					if (store && !store1 && !store2) begin
						lost_q <= 1'b1;
					end
					if (in_acc && s_tlast) begin
						i_q <= '0;
						j_q <= '0;
						sat_q <= 1'b0;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					side_q <= 1'b0;
					if (i_q < len1_q || j_q < len2_q) begin
						state_q <= S_ADDR;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_ADDR: begin
					if (p_in_range) begin
						state_q <= S_DATA;
					end else begin
						// end of string closes the revision
						if (side_q) begin
							j_q <= j_q + 1'b1;
							state_q <= S_CMP;
						end else begin
							i_q <= i_q + 1'b1;
							side_q <= 1'b1;
						end
					end
				end
				S_DATA: begin
					if (side_q) begin
						j_q <= j_q + 1'b1;
					end else begin
						i_q <= i_q + 1'b1;
					end
					if (d_cur == DOT_CODE) begin
						if (side_q) begin
							state_q <= S_CMP;
						end else begin
							side_q <= 1'b1;
							state_q <= S_ADDR;
						end
					end else begin
						if (acc_sat) begin
							sat_q <= 1'b1;
						end
						state_q <= S_ADDR;
					end
				end
				S_CMP: begin
					if (a_q != acc_q) begin
						state_q <= S_DONE;
					end else begin
						state_q <= S_CHK;
					end
				end
				S_DONE: begin
					if (out_free) begin
						len1_q <= '0;
						len2_q <= '0;
						lost_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// revision values, verdict and output payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				verdict_q <= VERDICT_EQUAL;
			end
			S_CHK: begin
				acc_q <= '0;
			end
			S_ADDR: begin
				if (!p_in_range && !side_q) begin
					a_q <= acc_q;
					acc_q <= '0;
				end
			end
			S_DATA: begin
				if (d_cur == DOT_CODE) begin
					if (!side_q) begin
						a_q <= acc_q;
						acc_q <= '0;
					end
				end else begin
					acc_q <= acc_next;
				end
			end
			S_CMP: begin
				if (a_q != acc_q) begin
					verdict_q <= (a_q > acc_q) ? VERDICT_FIRST : VERDICT_SECOND;
				end
			end
			S_DONE: begin
				if (out_free) begin
					out_verdict_q <= verdict_q;
					out_ovf_q <= lost_q || sat_q;
				end
			end
			default: begin
				verdict_q <= VERDICT_EQUAL;
			end
		endcase
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {6'b000000, out_verdict_q};
	assign m_tuser = out_ovf_q;

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !s_tready)
		else $error("input taken while comparing");

	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (out_verdict_q != 2'b10))
		else $error("verdict code out of range");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(len1_q <= MAX_LEN) && (len2_q <= MAX_LEN))
		else $error("buffer length beyond depth");

	a_data_after_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DATA) |-> ($past(state_q) == S_ADDR))
		else $error("buffer data used without a read");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_free) |=> (len1_q == '0 && len2_q == '0 && m_tvalid))
		else $error("result issued without clearing lengths");

endmodule
